@@ src/utme_pkg.sv @@
// ============================================================================
// utme_pkg
// Shared types and constants for the marker tail extractor.
// ============================================================================
package utme_pkg;

  localparam int ROOT_BYTES = 64;
  localparam int MARKER_LEN = 4;
  localparam int AFTER_SAT  = ROOT_BYTES + 1;
  localparam int WORD_BYTES = 8;
  localparam int NUM_WORDS  = ROOT_BYTES / WORD_BYTES;
  localparam int IDX_W      = $clog2(NUM_WORDS);
  localparam int AFTER_W    = $clog2(AFTER_SAT + 1);
  localparam int FILL_W     = $clog2(MARKER_LEN + 1);

  localparam logic [31:0] MARKER_RESET = 32'h5343_5233;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISSING   = 2'd1,
    ST_MULTIPLE  = 2'd2,
    ST_WRONG_LEN = 2'd3
  } utme_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       no_data;
    logic       last;
  } utme_in_t;

  typedef struct packed {
    utme_status_t status;
    logic [63:0]  root_word;
    logic [2:0]   word_index;
    logic         final_result;
  } utme_out_t;

  typedef struct packed {
    logic         take;
    logic         close;
  } utme_scan_ctl_t;

endpackage

@@ src/utme_cell.sv @@
// ============================================================================
// utme_cell
// One byte cell of the history chain; loads its neighbor's byte (the input byte for the first cell) on a shift.
// ============================================================================
module utme_cell (
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] d,
  output logic [7:0] q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

@@ src/utme_scan.sv @@
// ============================================================================
// utme_scan
// Marker compare and run counters; gives the outcome of the closing beat.
// ============================================================================
module utme_scan (
  input  logic                   clk,
  input  logic                   rst,
  input  utme_pkg::utme_scan_ctl_t ctl,
  input  logic [7:0]             byte_in,
  input  logic [23:0]            window_hi,
  input  logic [31:0]            marker,
  output utme_pkg::utme_status_t status
);
  import utme_pkg::*;

  logic [FILL_W-1:0]  fill_count, fill_count_next;
  logic [1:0]         match_count, match_count_next;
  logic [AFTER_W-1:0] bytes_after_match, bytes_after_match_next;
  logic               hit;

  always_comb begin
    fill_count_next        = fill_count;
    match_count_next       = match_count;
    bytes_after_match_next = bytes_after_match;
    hit                    = 1'b0;
    if (ctl.take) begin
      if (fill_count < FILL_W'(MARKER_LEN)) begin
        fill_count_next = fill_count + 1'b1;
      end
      hit = (fill_count_next >= FILL_W'(MARKER_LEN)) && ({window_hi, byte_in} == marker);
      if (hit) begin
        if (match_count < 2'd2) begin
          match_count_next = match_count + 1'b1;
        end
        bytes_after_match_next = '0;
      end else if (match_count != 2'd0) begin
        if (bytes_after_match < AFTER_W'(AFTER_SAT)) begin
          bytes_after_match_next = bytes_after_match + 1'b1;
        end
      end
    end
    priority if (match_count_next == 2'd0) begin
      status = ST_MISSING;
    end else if (match_count_next >= 2'd2) begin
      status = ST_MULTIPLE;
    end else if (bytes_after_match_next != AFTER_W'(ROOT_BYTES)) begin
      status = ST_WRONG_LEN;
    end else begin
      status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.close) begin
      fill_count        <= '0;
      match_count       <= '0;
      bytes_after_match <= '0;
    end else begin
      fill_count        <= fill_count_next;
      match_count       <= match_count_next;
      bytes_after_match <= bytes_after_match_next;
    end
  end

endmodule

@@ src/utme_outq.sv @@
// ============================================================================
// utme_outq
// Result holder: keeps the closing outcome, sends it one word per unstalled beat.
// ============================================================================
module utme_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  utme_pkg::utme_status_t          load_status,
  input  logic [utme_pkg::ROOT_BYTES*8-1:0] load_bytes,
  output logic                            can_load,
  output logic                            out_valid,
  input  logic                            out_stall,
  output utme_pkg::utme_out_t             out_data
);
  import utme_pkg::*;

  logic                    busy;
  utme_status_t            status;
  logic [IDX_W-1:0]        idx;
  logic [ROOT_BYTES*8-1:0] snap;
  logic                    pop;
  logic                    is_final;

  assign is_final  = (status != ST_OK) || (idx == IDX_W'(NUM_WORDS - 1));
  assign pop       = busy && !out_stall;
  assign can_load  = !busy || (pop && is_final);
  assign out_valid = busy;

  assign out_data.status       = status;
  assign out_data.root_word    = snap[ROOT_BYTES*8-1 -: 64];
  assign out_data.word_index   = 3'(idx);
  assign out_data.final_result = is_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (pop && is_final) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status <= load_status;
      idx    <= '0;
      snap   <= (load_status == ST_OK) ? load_bytes : '0;
    end else if (pop) begin
      idx  <= idx + 1'b1;
      snap <= snap << 64;
    end
  end

endmodule

@@ src/unique_tail_marker_extractor_top.sv @@
// ============================================================================
// unique_tail_marker_extractor_top
// Finds a four-byte marker in a byte string and returns the 64 bytes after it.
// ============================================================================
//  channel | dir | handshake        | payload
//  --------+-----+------------------+---------------------------------------
//  in      | in  | in_valid/stall   | data_byte, no_data, last
//  out     | out | out_valid/stall  | status, root_word, word_index, final
//  cfg     | in  | cfg_valid/ready  | marker prefix, 32 bits
//
//  One byte per cycle, when not stalled or no_data, through a 64-cell
//  shift chain; the compare sees the incoming byte and the newest three cells.
//  A closing beat loads the result holder; its first result is valid the next
//  cycle; one result (error) or eight words (success), one per unstalled beat.
//  A closing beat is stalled only while the holder still has words to send.
//  Reset clears counters and holder; chain contents are not cleared.
// ============================================================================
module unique_tail_marker_extractor_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  utme_pkg::utme_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output utme_pkg::utme_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);
  import utme_pkg::*;

  logic [31:0]             marker;
  logic                    accept;
  logic                    can_load;
  utme_scan_ctl_t          ctl;
  utme_status_t            status;
  logic [7:0]              chain [ROOT_BYTES];
  logic [ROOT_BYTES*8-1:0] tail_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= MARKER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      marker <= cfg_data;
    end
  end

  assign in_stall  = in_data.last && !can_load;
  assign accept    = in_valid && !in_stall;
  assign ctl.take  = accept && !in_data.no_data;
  assign ctl.close = accept && in_data.last;

  utme_cell u_cell0 (
    .clk   (clk),
    .shift (ctl.take),
    .d     (in_data.data_byte),
    .q     (chain[0])
  );

  for (genvar i = 1; i < ROOT_BYTES; i++) begin : g_chain
    utme_cell u_cell (
      .clk   (clk),
      .shift (ctl.take),
      .d     (chain[i-1]),
      .q     (chain[i])
    );
  end

  // bytes as they stand after this beat's shift; oldest in the top byte
  always_comb begin
    tail_bytes[7:0] = ctl.take ? in_data.data_byte : chain[0];
    for (int i = 1; i < ROOT_BYTES; i++) begin
      tail_bytes[i*8 +: 8] = ctl.take ? chain[i-1] : chain[i];
    end
  end

  utme_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .byte_in   (in_data.data_byte),
    .window_hi ({chain[2], chain[1], chain[0]}),
    .marker    (marker),
    .status    (status)
  );

  utme_outq u_outq (
    .clk         (clk),
    .rst         (rst),
    .load        (ctl.close),
    .load_status (status),
    .load_bytes  (tail_bytes),
    .can_load    (can_load),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

@@ src/utme_checker.sv @@
// ============================================================================
// utme_checker
// Port-level checks on the result stream of the extractor.
// ============================================================================
module utme_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input utme_pkg::utme_out_t out_data
);
  import utme_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_word_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.final_result |=>
      out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1)
    else $error("success words not contiguous");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_OK |->
      out_data.final_result && out_data.word_index == 3'd0 && out_data.root_word == 64'd0)
    else $error("bad error beat");

  a_ok_final: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == ST_OK |->
      out_data.final_result == (out_data.word_index == 3'd7))
    else $error("final flag misplaced");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind unique_tail_marker_extractor_top utme_checker u_utme_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ verif/utme_tail_checker.sv @@
// ----------------------------------------------------------------------------
// utme_tail_checker
// Watches the config, input and result channels of the marker tail extractor,
// keeps its own copy of the scan state, works out the outcome of every closed
// string and compares each result beat field by field, oldest first.
// ----------------------------------------------------------------------------
module utme_tail_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  utme_pkg::utme_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  utme_pkg::utme_out_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  owed_count,
  output int                  words_checked,
  output int                  strings_closed,
  output int                  roots_found
);
  timeunit 1ns;
  timeprecision 1ps;
  import utme_pkg::*;

  logic [31:0]        marker;
  logic [31:0]        window;
  logic [FILL_W-1:0]  filled;
  logic [1:0]         hits;
  logic [AFTER_W-1:0] trailing;
  logic [7:0]         tail [ROOT_BYTES];
  utme_out_t          owed [$];

  task automatic report(input string msg);
    fail_count++;
    if (fail_count <= 40) $display("%0t ns utme mismatch: %s", $time, msg);
  endtask

  task automatic clear_scan();
    window   = '0;
    filled   = '0;
    hits     = '0;
    trailing = '0;
  endtask

  task automatic scan_byte(input logic [7:0] b);
    window = {window[23:0], b};
    if (filled < MARKER_LEN) filled++;
    if (filled == MARKER_LEN && window == marker) begin
      if (hits < 2) hits++;
      trailing = '0;
    end else if (hits != 0) begin
      if (trailing < ROOT_BYTES) tail[trailing[5:0]] = b;
      if (trailing < AFTER_SAT) trailing++;
    end
  endtask

  task automatic close_string();
    utme_out_t    r;
    utme_status_t st;
    if (hits == 0) st = ST_MISSING;
    else if (hits >= 2) st = ST_MULTIPLE;
    else if (trailing != ROOT_BYTES) st = ST_WRONG_LEN;
    else st = ST_OK;
    strings_closed++;
    if (st == ST_OK) begin
      roots_found++;
      for (int w = 0; w < NUM_WORDS; w++) begin
        r.status = ST_OK;
        for (int k = 0; k < WORD_BYTES; k++)
          r.root_word = {r.root_word[55:0], tail[w * WORD_BYTES + k]};
        r.word_index   = 3'(w);
        r.final_result = (w == NUM_WORDS - 1);
        owed = {owed, r};
      end
    end else begin
      r = '{status: st, root_word: '0, word_index: '0, final_result: 1'b1};
      owed = {owed, r};
    end
    clear_scan();
  endtask

  task automatic check_result(input utme_out_t got);
    utme_out_t want;
    words_checked++;
    if (owed.size() == 0) begin
      report($sformatf("result beat with nothing owed: status %0d word %h index %0d",
                       got.status, got.root_word, got.word_index));
      return;
    end
    want = owed.pop_front();
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.root_word !== want.root_word)
      report($sformatf("root_word %h, want %h (index %0d)",
                       got.root_word, want.root_word, want.word_index));
    if (got.word_index !== want.word_index)
      report($sformatf("word_index %0d, want %0d", got.word_index, want.word_index));
    if (got.final_result !== want.final_result)
      report($sformatf("final_result %b, want %b (index %0d)",
                       got.final_result, want.final_result, want.word_index));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      marker = MARKER_RESET;
      clear_scan();
      owed.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (cfg_valid && cfg_ready) marker = cfg_data;
      if (in_valid && !in_stall) begin
        if (!in_data.no_data) scan_byte(in_data.data_byte);
        if (in_data.last) close_string();
      end
    end
    owed_count = owed.size();
  end

endmodule

@@ verif/tb_unique_tail_marker_extractor_top.sv @@
// ----------------------------------------------------------------------------
// tb_unique_tail_marker_extractor_top
// Drives byte strings into the marker tail extractor under random idle and
// stall patterns: a directed opener for each error outcome, then random phases
// mixing marker-plus-64-byte strings and error strings, one marker per phase.
// ----------------------------------------------------------------------------
module tb_unique_tail_marker_extractor_top;
  timeunit 1ns;
  timeprecision 1ps;
  import utme_pkg::*;

  localparam int DRAIN       = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER  = 150;
  localparam int PHASE_ITEMS = 65;
  localparam int LIMIT       = 200000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  utme_in_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  utme_out_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  int fail_count;
  int owed_count;
  int words_checked;
  int strings_closed;
  int roots_found;

  int          items_sent = 0;
  int          settings   = 1;
  int          cycle_count;
  int          tx_left    = 0;
  bit          tx_calm    = 1'b0;
  int          rx_left    = 0;
  bit          rx_calm    = 1'b0;
  logic [31:0] marker_now = MARKER_RESET;
  logic [7:0]  script [$];

  unique_tail_marker_extractor_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  utme_tail_checker i_tail_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .owed_count     (owed_count),
    .words_checked  (words_checked),
    .strings_closed (strings_closed),
    .roots_found    (roots_found)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // idle draw per beat, in stretches that are either busy or idle-free
  function automatic int pick_gap(inout int left, inout bit calm);
    if (left == 0) begin
      calm = ($urandom_range(0, 2) == 0);
      left = $urandom_range(8, 40);
    end
    left--;
    return calm ? 0 : int'($urandom_range(0, 13));
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic nd, input logic lst);
    int gap;
    gap = pick_gap(tx_left, tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= '{data_byte: b, no_data: nd, last: lst};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    if (!nd || lst) items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (owed_count != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_marker(input logic [31:0] m);
    settle();
    cfg_data  <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    marker_now = m;
    settings++;
  endtask

  task automatic append_byte(input logic [7:0] b);
    script = {script, b};
  endtask

  task automatic push_marker();
    for (int k = 0; k < 4; k++) append_byte(marker_now[31 - 8 * k -: 8]);
  endtask

  task automatic push_random(input int n);
    repeat (n) append_byte(8'($urandom));
  endtask

  // close: end the string; split: allow a separate empty closing beat
  task automatic send_script(input bit split_ok, input bit close);
    bit split;
    split = close && (script.size() == 0 || (split_ok && $urandom_range(0, 3) == 0));
    foreach (script[i]) begin
      if ($urandom_range(0, 11) == 0) send_beat(8'($urandom), 1'b1, 1'b0);
      send_beat(script[i], 1'b0, close && !split && i == script.size() - 1);
    end
    if (split) send_beat(8'($urandom), 1'b1, 1'b1);
    script.delete();
  endtask

  task automatic build_script();
    int kind;
    kind = $urandom_range(0, 9);
    script.delete();
    case (kind)
      0, 1, 2, 3: begin
        push_random($urandom_range(0, 6));
        push_marker();
        push_random(ROOT_BYTES);
      end
      4: begin
        push_random($urandom_range(0, 3));
        push_marker();
        push_random($urandom_range(60, 70));
      end
      5: begin
        push_random($urandom_range(0, 4));
        push_marker();
        push_random($urandom_range(0, 8));
        push_marker();
        push_random(ROOT_BYTES);
      end
      6: push_random($urandom_range(1, 12));
      7: begin
        push_marker();
        push_random($urandom_range(0, 10));
      end
      8: ;
      default: push_random($urandom_range(1, 20));
    endcase
  endtask

  task automatic run_phase(input logic [31:0] m);
    int start;
    write_marker(m);
    start = items_sent;
    while (items_sent - start < PHASE_ITEMS) begin
      build_script();
      send_script(1'b1, 1'b1);
    end
  endtask

  // result side: random stall per beat, one long hold-off mid-run
  initial begin
    int gap;
    bit held;
    held = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = pick_gap(rx_left, rx_calm);
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", LIMIT, owed_count);
    $display("[unique_tail_marker_extractor_top] ERROR");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty string
    send_beat(8'h00, 1'b1, 1'b1);
    // ignored beat, then a string too short to fill the window
    send_beat(8'hFF, 1'b1, 1'b0);
    script = '{8'h00, 8'hFF};
    send_script(1'b0, 1'b1);
    // marker closed early: wrong length
    push_marker();
    append_byte(8'h00);
    send_script(1'b0, 1'b1);
    // back-to-back markers
    push_marker();
    push_marker();
    send_script(1'b0, 1'b1);
    // marker changed mid-string, then overlapping matches
    script = '{8'h53, 8'h43, 8'h52};
    send_script(1'b0, 1'b0);
    write_marker(32'hAAAA_AAAA);
    push_random(0);
    repeat (5) append_byte(8'hAA);
    send_script(1'b0, 1'b1);

    run_phase(32'h0000_0000);
    run_phase(32'hFFFF_FFFF);
    run_phase($urandom);
    run_phase(MARKER_RESET);
    run_phase($urandom);

    settle();
    $display("run covered %0d input beats over %0d marker settings, with a %0d-cycle hold-off",
             items_sent, settings, HOLD_CYCLES);
    $display("checked %0d result beats from %0d strings, %0d of them carrying roots",
             words_checked, strings_closed, roots_found);
    if (fail_count == 0) begin
      $display("[unique_tail_marker_extractor_top] OK");
    end else begin
      $display("[unique_tail_marker_extractor_top] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/utme_pkg.sv
src/utme_cell.sv
src/utme_scan.sv
src/utme_outq.sv
src/unique_tail_marker_extractor_top.sv
src/utme_checker.sv
verif/utme_tail_checker.sv
verif/tb_unique_tail_marker_extractor_top.sv
